@@ rtl/queued_mutex_lock_server_assert.svh @@
// assertion macros for the queued mutex lock server
// needs i_clk and the active-low i_rst_n in the scope that uses them
`ifndef QUEUED_MUTEX_LOCK_SERVER_ASSERT_SVH
`define QUEUED_MUTEX_LOCK_SERVER_ASSERT_SVH

// same-cycle implication, off during reset
`define QMLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lock server check failed");

// next-cycle implication, off during reset
`define QMLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lock server check failed");

`endif

@@ rtl/qmls_pkg.sv @@
// shared types and codes of the queued mutex lock server
// no dependencies
`timescale 1ns / 1ps

package qmls_pkg;

    // field widths
    localparam int PEER_W = 6;
    localparam int IDX_W  = 8;
    localparam int OP_W   = 2;
    localparam int ERR_W  = 2;
    localparam int CNT_W  = 9;

    // index and peer spans the fields can reach
    localparam int IDX_SPAN  = 256;
    localparam int PEER_SPAN = 64;

    // operations
    localparam logic [OP_W-1:0] OP_LOCK    = 2'd0;
    localparam logic [OP_W-1:0] OP_TRYLOCK = 2'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd2;
    localparam logic [OP_W-1:0] OP_INVALID = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_OWNER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_OP    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd3;

    // reset value of the mutex limit register
    localparam logic [CNT_W-1:0] MUTEX_LIMIT_RESET = 9'd256;

    // one row of the mutex table: owner and wait list ends
    typedef struct packed {
        logic              held;
        logic [PEER_W-1:0] owner;
        logic              nonempty;
        logic [PEER_W-1:0] head;
        logic [PEER_W-1:0] tail;
    } t_row;

    // one response item
    typedef struct packed {
        logic [PEER_W-1:0] dest_peer;
        logic              granted;
        logic [ERR_W-1:0]  error_code;
    } t_resp;

endpackage

@@ rtl/qmls_mutex_mem.sv @@
// mutex table memory: owner, head and tail per mutex, registered read
// row valid bits give the cleared value after reset; uses qmls_pkg
`timescale 1ns / 1ps

module qmls_mutex_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output qmls_pkg::t_row     o_rd_row,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  qmls_pkg::t_row     i_wr_row
);
    import qmls_pkg::*;

    t_row       mem [DEPTH];
    logic       r_valid [DEPTH];
    t_row       r_rd_data;
    logic       r_rd_valid;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_row;
        end
    end

    // row valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // a row never written reads as free and empty
    assign o_rd_row = r_rd_valid ? r_rd_data : '0;

endmodule

@@ rtl/qmls_link_mem.sv @@
// waiter link memory: the peer queued behind each peer, registered read
// entries are undefined until written; uses qmls_pkg
`timescale 1ns / 1ps

module qmls_link_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [qmls_pkg::PEER_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [qmls_pkg::PEER_W-1:0] i_wr_data
);
    import qmls_pkg::*;

    logic [PEER_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/qmls_ctrl.sv @@
// request sequencer: read-modify-write of one mutex row per item,
// link lookup on handoff, output register; uses qmls_pkg
`timescale 1ns / 1ps

module qmls_ctrl #(
    parameter int NUM_MUTEXES = 256,
    parameter int NUM_PEERS   = 64,
    parameter int AW          = 8,
    parameter int LAW         = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [qmls_pkg::OP_W-1:0]   i_operation,
    input  logic [qmls_pkg::IDX_W-1:0]  i_mutex_index,
    input  logic [qmls_pkg::PEER_W-1:0] i_requester_peer,
    input  logic [qmls_pkg::CNT_W-1:0]  i_mutex_limit,
    // mutex table
    output logic                        o_row_rd_en,
    output logic [AW-1:0]               o_row_rd_addr,
    input  qmls_pkg::t_row              i_row,
    output logic                        o_row_wr_en,
    output logic [AW-1:0]               o_row_wr_addr,
    output qmls_pkg::t_row              o_row_wr_row,
    // link table
    output logic                        o_link_rd_en,
    output logic [LAW-1:0]              o_link_rd_addr,
    input  logic [qmls_pkg::PEER_W-1:0] i_link_data,
    output logic                        o_link_wr_en,
    output logic [LAW-1:0]              o_link_wr_addr,
    output logic [qmls_pkg::PEER_W-1:0] o_link_wr_data,
    // response channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output qmls_pkg::t_resp             o_resp
);
    import qmls_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    // peer to link entry, peer modulo NUM_PEERS, built at elaboration
    function automatic logic [PEER_SPAN*LAW-1:0] build_link_map();
        logic [PEER_SPAN*LAW-1:0] map;
        map = '0;
        for (int i = 0; i < PEER_SPAN; i++) begin
            map[i*LAW +: LAW] = LAW'(i % NUM_PEERS);
        end
        return map;
    endfunction

    localparam logic [PEER_SPAN*LAW-1:0] LINK_MAP = build_link_map();

    function automatic logic [LAW-1:0] link_addr(input logic [PEER_W-1:0] peer);
        return LINK_MAP[int'(peer)*LAW +: LAW];
    endfunction

    logic [1:0]        r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [PEER_W-1:0] r_peer;
    logic              r_out_valid, n_out_valid;
    t_resp             r_resp;

    logic              accept;
    logic              out_free;
    logic              bad_op;
    logic              out_of_range;
    logic              res_need;
    t_resp             res;
    logic              row_we;
    logic              link_we;
    logic              go_link;
    logic              commit;
    t_row              new_row;

    // no item is taken while reset is held
    assign accept       = i_in_valid && i_rst_n && (r_state == S_IDLE);
    assign o_in_stall   = !i_rst_n || (r_state != S_IDLE);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign bad_op       = (r_op == OP_INVALID);
    assign out_of_range = ({1'b0, r_idx} >= i_mutex_limit)
                       || ({24'd0, r_idx} >= 32'(NUM_MUTEXES));

    // row read is issued at the accepting edge
    assign o_row_rd_en   = accept;
    assign o_row_rd_addr = i_mutex_index[AW-1:0];

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_idx  <= i_mutex_index;
            r_peer <= i_requester_peer;
        end
    end

    // decide the row update and the response
    always_comb begin
        res_need = 1'b0;
        res      = '{dest_peer: r_peer, granted: 1'b0, error_code: ERR_OK};
        row_we   = 1'b0;
        link_we  = 1'b0;
        go_link  = 1'b0;
        new_row  = i_row;
        unique case (r_state)
            S_EXEC: begin
                if (bad_op) begin
                    res_need       = 1'b1;
                    res.error_code = ERR_BAD_OP;
                end else if (out_of_range) begin
                    res_need       = 1'b1;
                    res.error_code = ERR_RANGE;
                end else if (r_op == OP_UNLOCK) begin
                    if (!i_row.held || (i_row.owner != r_peer)) begin
                        res_need       = 1'b1;
                        res.error_code = ERR_NOT_OWNER;
                    end else if (!i_row.nonempty) begin
                        // no waiter: free the mutex
                        row_we        = 1'b1;
                        new_row.held  = 1'b0;
                        new_row.owner = '0;
                    end else if (i_row.head == i_row.tail) begin
                        // last waiter takes over, list empties
                        row_we           = 1'b1;
                        new_row.owner    = i_row.head;
                        new_row.nonempty = 1'b0;
                        new_row.head     = '0;
                        new_row.tail     = '0;
                        res_need         = 1'b1;
                        res.dest_peer    = i_row.head;
                        res.granted      = 1'b1;
                    end else begin
                        go_link = 1'b1;
                    end
                end else if (!i_row.held) begin
                    // lock or trylock on a free mutex
                    row_we        = 1'b1;
                    new_row.held  = 1'b1;
                    new_row.owner = r_peer;
                    res_need      = 1'b1;
                    res.granted   = 1'b1;
                end else if (r_op == OP_TRYLOCK) begin
                    res_need = 1'b1;
                end else begin
                    // lock on a held mutex: append to the wait list
                    row_we       = 1'b1;
                    new_row.tail = r_peer;
                    if (!i_row.nonempty) begin
                        new_row.nonempty = 1'b1;
                        new_row.head     = r_peer;
                    end else begin
                        link_we = 1'b1;
                    end
                end
            end
            S_LINK: begin
                // head waiter takes over, its link becomes the new head
                row_we        = 1'b1;
                new_row.owner = i_row.head;
                new_row.head  = i_link_data;
                res_need      = 1'b1;
                res.dest_peer = i_row.head;
                res.granted   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // a step finishes once its response, if any, has a free slot
    assign commit = (r_state != S_IDLE) && !go_link && (!res_need || out_free);

    assign o_row_wr_en    = commit && row_we;
    assign o_row_wr_addr  = r_idx[AW-1:0];
    assign o_row_wr_row   = new_row;
    assign o_link_wr_en   = commit && link_we;
    assign o_link_wr_addr = link_addr(i_row.tail);
    assign o_link_wr_data = r_peer;
    assign o_link_rd_en   = go_link;
    assign o_link_rd_addr = link_addr(i_row.head);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (go_link) begin
                    n_state = S_LINK;
                end else if (commit) begin
                    n_state = S_IDLE;
                end
            end
            S_LINK: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (commit && res_need) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && res_need) begin
            r_resp <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_resp      = r_resp;

endmodule

@@ rtl/queued_mutex_lock_server.sv @@
// top level of the queued mutex lock server
// uses qmls_pkg, qmls_mutex_mem, qmls_link_mem, qmls_ctrl and the assert header
`timescale 1ns / 1ps
//
//  channel   handshake                  payload
//  request   i_in_valid / o_in_stall    i_operation, i_mutex_index, i_requester_peer
//  response  o_out_valid / i_out_stall  o_dest_peer, o_granted, o_error_code
//  config    i_cfg_we                   i_cfg_data (mutex limit)
//
//  one item at a time: each item reads its mutex table row, which is
//  registered, and then writes it back; an unlock that hands over to a
//  waiter with others behind it also waits for the dependent link table read.
//  reset is synchronous; row valid bits clear the mutex table at once,
//  so items are taken from the first cycle after reset.
//  the next item can be taken while a response waits; if it answers too,
//  it stays in its last step until the response slot frees.

module queued_mutex_lock_server #(
    parameter int NUM_MUTEXES = 256,
    parameter int NUM_PEERS   = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [qmls_pkg::OP_W-1:0]   i_operation,
    input  logic [qmls_pkg::IDX_W-1:0]  i_mutex_index,
    input  logic [qmls_pkg::PEER_W-1:0] i_requester_peer,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [qmls_pkg::PEER_W-1:0] o_dest_peer,
    output logic                        o_granted,
    output logic [qmls_pkg::ERR_W-1:0]  o_error_code,
    input  logic                        i_cfg_we,
    input  logic [qmls_pkg::CNT_W-1:0]  i_cfg_data
);
    import qmls_pkg::*;

    `include "queued_mutex_lock_server_assert.svh"

    // table sizes reachable by the fields
    localparam int MUTEX_DEPTH = (NUM_MUTEXES < IDX_SPAN) ? NUM_MUTEXES : IDX_SPAN;
    localparam int LINK_DEPTH  = (NUM_PEERS < PEER_SPAN) ? NUM_PEERS : PEER_SPAN;
    localparam int AW          = (MUTEX_DEPTH > 1) ? $clog2(MUTEX_DEPTH) : 1;
    localparam int LAW         = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;

    logic [CNT_W-1:0]  r_mutex_limit;
    logic              row_rd_en;
    logic [AW-1:0]     row_rd_addr;
    t_row              row_rd;
    logic              row_wr_en;
    logic [AW-1:0]     row_wr_addr;
    t_row              row_wr;
    logic              link_rd_en;
    logic [LAW-1:0]    link_rd_addr;
    logic [PEER_W-1:0] link_rd_data;
    logic              link_wr_en;
    logic [LAW-1:0]    link_wr_addr;
    logic [PEER_W-1:0] link_wr_data;
    t_resp             resp;

    // mutex limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mutex_limit <= MUTEX_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_mutex_limit <= i_cfg_data;
        end
    end

    qmls_mutex_mem #(
        .DEPTH (MUTEX_DEPTH),
        .AW    (AW)
    ) u_mutex_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (row_rd_en),
        .i_rd_addr (row_rd_addr),
        .o_rd_row  (row_rd),
        .i_wr_en   (row_wr_en),
        .i_wr_addr (row_wr_addr),
        .i_wr_row  (row_wr)
    );

    qmls_link_mem #(
        .DEPTH (LINK_DEPTH),
        .AW    (LAW)
    ) u_link_mem (
        .i_clk     (i_clk),
        .i_rd_en   (link_rd_en),
        .i_rd_addr (link_rd_addr),
        .o_rd_data (link_rd_data),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data)
    );

    qmls_ctrl #(
        .NUM_MUTEXES (NUM_MUTEXES),
        .NUM_PEERS   (NUM_PEERS),
        .AW          (AW),
        .LAW         (LAW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_mutex_index    (i_mutex_index),
        .i_requester_peer (i_requester_peer),
        .i_mutex_limit    (r_mutex_limit),
        .o_row_rd_en      (row_rd_en),
        .o_row_rd_addr    (row_rd_addr),
        .i_row            (row_rd),
        .o_row_wr_en      (row_wr_en),
        .o_row_wr_addr    (row_wr_addr),
        .o_row_wr_row     (row_wr),
        .o_link_rd_en     (link_rd_en),
        .o_link_rd_addr   (link_rd_addr),
        .i_link_data      (link_rd_data),
        .o_link_wr_en     (link_wr_en),
        .o_link_wr_addr   (link_wr_addr),
        .o_link_wr_data   (link_wr_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_resp           (resp)
    );

    assign o_dest_peer  = resp.dest_peer;
    assign o_granted    = resp.granted;
    assign o_error_code = resp.error_code;

    // an accepted item blocks the request side for its read-back cycle
    `QMLS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // a row is never read and rewritten in the same cycle
    `QMLS_ASSERT_IMP(a_row_rd_wr_apart, row_rd_en, !row_wr_en)
    // the link table is never read and written in the same cycle
    `QMLS_ASSERT_IMP(a_link_rd_wr_apart, link_rd_en, !link_wr_en)
    // a new response only comes from an item in progress
    `QMLS_ASSERT_IMP(a_resp_from_item, $rose(o_out_valid), $past(o_in_stall))

endmodule
